[rtl/hnc_pkg.sv]
// Package for the hashed name cache: command codes, controller states,
// slot metadata layout and default sizes. No dependencies.
package hnc_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int MAX_ADDRESSES_DEF = 64;
  localparam int KEY_BYTES_DEF     = 256;
  localparam int HASH_SEED         = 5381;
  localparam int HASH_MULT         = 33;
  localparam int TTL_RESET         = 60;

  localparam int CMD_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 7;
  localparam int TTL_W   = 16;
  localparam int STAMP_W = 32;
  localparam int KLEN_W  = 8;

  localparam logic [CMD_W-1:0] CMD_KEY_BYTE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_ADDR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STORE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_LK_META,
    ST_LK_CMP,
    ST_LK_AGE,
    ST_MISS,
    ST_EMPTY,
    ST_ADDR_RD,
    ST_ADDR_DATA,
    ST_ST_KEY,
    ST_ST_ADDR,
    ST_ST_META
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [KLEN_W-1:0]  key_len;
    logic [COUNT_W-1:0] addr_cnt;
    logic [STAMP_W-1:0] stamp;
  } meta_t;

endpackage

[rtl/hnc_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/hnc_hash.sv]
// djb2 hash unit: hash*33+byte, reduced modulo the table size by a
// reciprocal multiply and one correcting subtract. Uses hnc_pkg.
module hnc_hash #(
  parameter int TABLE_ENTRIES = hnc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             restart,
  input  logic [hnc_pkg::BYTE_W-1:0]       byte_in,
  output logic                             busy,
  output logic [$clog2(TABLE_ENTRIES)-1:0] hash
);
  import hnc_pkg::*;

  localparam int HW = $clog2(TABLE_ENTRIES);
  localparam int VW = HW + 9;
  localparam int QW = 8;
  localparam logic [HW-1:0] SEED_MOD = HW'(HASH_SEED % TABLE_ENTRIES);
  // floor(2^VW / TABLE_ENTRIES): quotient estimate is exact or one low
  localparam longint RECIP_L = (longint'(1) << VW) / longint'(TABLE_ENTRIES);
  localparam logic [VW-1:0] RECIP = VW'(RECIP_L);
  localparam logic [VW-1:0] TE_V  = VW'(TABLE_ENTRIES);

  logic [HW-1:0]   h_r, h_nxt;
  logic [VW-1:0]   v_r, v_nxt;
  logic [QW-1:0]   q_r, q_nxt;
  logic            k_r, k_nxt;
  logic            busy_r, busy_nxt;
  logic [HW-1:0]   base;
  logic [2*VW-1:0] prod;
  logic [VW-1:0]   qte;
  logic [VW-1:0]   r_full;
  logic [VW-1:0]   r_red;

  always_comb begin
    base   = restart ? SEED_MOD : h_r;
    prod   = (2*VW)'(v_r) * (2*VW)'(RECIP);
    qte    = VW'(q_r) * TE_V;
    r_full = v_r - qte;
    r_red  = (r_full >= TE_V) ? (r_full - TE_V) : r_full;
    h_nxt    = h_r;
    v_nxt    = v_r;
    q_nxt    = q_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      if (k_r) begin
        q_nxt = prod[VW +: QW];
        k_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b0;
        h_nxt    = r_red[HW-1:0];
      end
    end else if (start) begin
      v_nxt    = (VW'(base) << 5) + VW'(base) + VW'(byte_in);
      k_nxt    = 1'b1;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r    <= SEED_MOD;
      busy_r <= 1'b0;
      k_r    <= 1'b0;
    end else begin
      h_r    <= h_nxt;
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
    v_r <= v_nxt;
    q_r <= q_nxt;
  end

  assign busy = busy_r;
  assign hash = h_r;

endmodule

[rtl/hashed_name_cache_with_expiry.sv]
// Top level of the hashed name cache with expiry: controller and slot
// memories. Uses hnc_pkg, hnc_ram and hnc_hash.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+--------------------------------------
//   in      | in  | in_valid/in_stall  | command, key_byte, address_value
//   out     | out | out_valid/out_stall| hit, address, address_count, last
//   cfg     | in  | cfg_we             | cfg_wdata = ttl_seconds
//
// Sequencing: tick, add-address and overlong store finish in idle; a key
//   byte waits for the hash unit's quotient estimate and correcting
//   subtract. A lookup reads the metadata, compares the key one byte per
//   cycle through the key memories, checks the age, then reads and emits
//   each address. A store copies key bytes and addresses one per cycle.
// Reset: a clearing pass writes every slot's metadata invalid, one slot a
//   cycle, with in_stall high.
// Stalls: results leave through an output register; out_stall only holds
//   the block while another result is waiting to go out.
module hashed_name_cache_with_expiry #(
  parameter int TABLE_ENTRIES = hnc_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_ADDRESSES = hnc_pkg::MAX_ADDRESSES_DEF,
  parameter int KEY_BYTES     = hnc_pkg::KEY_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hnc_pkg::CMD_W-1:0]    in_command,
  input  logic [hnc_pkg::BYTE_W-1:0]   in_key_byte,
  input  logic [hnc_pkg::ADDR_W-1:0]   in_address_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic [hnc_pkg::ADDR_W-1:0]   out_address,
  output logic [hnc_pkg::COUNT_W-1:0]  out_address_count,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [hnc_pkg::TTL_W-1:0]    cfg_wdata
);
  import hnc_pkg::*;

  localparam int HW  = $clog2(TABLE_ENTRIES);
  localparam int KW  = $clog2(KEY_BYTES);
  localparam int PLW = $clog2(KEY_BYTES + 1);
  localparam int AIW = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1;
  localparam int CW  = $clog2(MAX_ADDRESSES + 1);
  localparam int IW  = (PLW > CW) ? PLW : CW;
  localparam int KEY_DEPTH  = TABLE_ENTRIES * (1 << KW);
  localparam int ADDR_DEPTH = TABLE_ENTRIES * (1 << AIW);
  localparam int META_W     = $bits(meta_t);

  // ---------------------------------------------------------------- state
  state_t state_r, state_nxt;

  logic [TTL_W-1:0]   ttl_r;
  logic [STAMP_W-1:0] now_r, now_nxt;
  logic [PLW-1:0]     plen_r, plen_nxt;
  logic [CW-1:0]      pcnt_r, pcnt_nxt;
  logic               closed_r, closed_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               pipe_r, pipe_nxt;      // read issued last cycle
  logic               mism_r, mism_nxt;
  logic [HW-1:0]      clr_r, clr_nxt;

  logic               ov_r, ov_nxt;
  logic               oh_r, oh_nxt;
  logic [ADDR_W-1:0]  oa_r, oa_nxt;
  logic [COUNT_W-1:0] oc_r, oc_nxt;
  logic               ol_r, ol_nxt;

  // ---------------------------------------------------------------- hash
  logic          h_start, h_restart, h_busy;
  logic [HW-1:0] slot;

  hnc_hash #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (h_start),
    .restart (h_restart),
    .byte_in (in_key_byte),
    .busy    (h_busy),
    .hash    (slot)
  );

  // ---------------------------------------------------------------- memories
  logic               pk_we, pk_re;
  logic [KW-1:0]      pk_waddr, pk_raddr;
  logic [BYTE_W-1:0]  pk_rdata;
  logic               pa_we, pa_re;
  logic [AIW-1:0]     pa_waddr, pa_raddr;
  logic [ADDR_W-1:0]  pa_rdata;
  logic               sk_we, sk_re;
  logic [HW+KW-1:0]   sk_waddr, sk_raddr;
  logic [BYTE_W-1:0]  sk_rdata;
  logic               sa_we, sa_re;
  logic [HW+AIW-1:0]  sa_waddr, sa_raddr;
  logic [ADDR_W-1:0]  sa_rdata;
  logic               m_we, m_re;
  logic [HW-1:0]      m_waddr;
  meta_t              m_wdata, m_rdata;
  logic [META_W-1:0]  m_rbits;

  hnc_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_BYTES)) u_pend_key (
    .clk(clk), .we(pk_we), .waddr(pk_waddr), .wdata(in_key_byte),
    .re(pk_re), .raddr(pk_raddr), .rdata(pk_rdata)
  );

  hnc_ram #(.WIDTH(ADDR_W), .DEPTH(1 << AIW)) u_pend_addr (
    .clk(clk), .we(pa_we), .waddr(pa_waddr), .wdata(in_address_value),
    .re(pa_re), .raddr(pa_raddr), .rdata(pa_rdata)
  );

  hnc_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_DEPTH)) u_slot_key (
    .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(pk_rdata),
    .re(sk_re), .raddr(sk_raddr), .rdata(sk_rdata)
  );

  hnc_ram #(.WIDTH(ADDR_W), .DEPTH(ADDR_DEPTH)) u_slot_addr (
    .clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(pa_rdata),
    .re(sa_re), .raddr(sa_raddr), .rdata(sa_rdata)
  );

  hnc_ram #(.WIDTH(META_W), .DEPTH(TABLE_ENTRIES)) u_meta (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(slot), .rdata(m_rbits)
  );

  assign m_rdata = meta_t'(m_rbits);

  // ---------------------------------------------------------------- decode
  logic              acc;
  logic              free;        // output register can take a result
  logic              overlong;
  logic [IW-1:0]     plen_w, pcnt_w, mlen_w, mcnt_w, widx;
  logic [PLW-1:0]    base_len;
  logic [STAMP_W-1:0] age;
  logic              expired;

  assign acc      = in_valid && !in_stall;
  assign free     = !ov_r || !out_stall;
  assign overlong = plen_r > PLW'(KEY_BYTES - 1);
  assign plen_w   = IW'(plen_r);
  assign pcnt_w   = IW'(pcnt_r);
  assign mlen_w   = IW'(m_rdata.key_len);
  assign mcnt_w   = IW'(m_rdata.addr_cnt);
  assign widx     = idx_r - IW'(1);
  assign base_len = closed_r ? '0 : plen_r;
  assign age      = now_r - m_rdata.stamp;
  assign expired  = age > STAMP_W'(ttl_r);

  assign pk_waddr = base_len[KW-1:0];
  assign pk_raddr = idx_r[KW-1:0];
  assign pa_waddr = pcnt_r[AIW-1:0];
  assign pa_raddr = idx_r[AIW-1:0];
  assign sk_raddr = {slot, idx_r[KW-1:0]};
  assign sk_waddr = {slot, widx[KW-1:0]};
  assign sa_raddr = {slot, idx_r[AIW-1:0]};
  assign sa_waddr = {slot, widx[AIW-1:0]};

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == HW'(TABLE_ENTRIES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_command)
            CMD_KEY_BYTE: if (in_key_byte != '0) state_nxt = ST_HASH;
            CMD_LOOKUP:   state_nxt = overlong ? ST_MISS : ST_LK_META;
            CMD_STORE:    if (!overlong) state_nxt = ST_ST_KEY;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_HASH: if (!h_busy) state_nxt = ST_IDLE;
      ST_LK_META: begin
        if (!m_rdata.valid || mlen_w != plen_w) state_nxt = ST_MISS;
        else state_nxt = ST_LK_CMP;
      end
      ST_LK_CMP: begin
        if (idx_r == plen_w && !pipe_r) state_nxt = mism_r ? ST_MISS : ST_LK_AGE;
      end
      ST_LK_AGE: begin
        if (expired) state_nxt = ST_MISS;
        else if (mcnt_w == '0) state_nxt = ST_EMPTY;
        else state_nxt = ST_ADDR_RD;
      end
      ST_MISS, ST_EMPTY: if (free) state_nxt = ST_IDLE;
      ST_ADDR_RD: state_nxt = ST_ADDR_DATA;
      ST_ADDR_DATA: begin
        if (free) state_nxt = (idx_r + IW'(1) == mcnt_w) ? ST_IDLE : ST_ADDR_RD;
      end
      ST_ST_KEY: if (idx_r == plen_w && !pipe_r) state_nxt = ST_ST_ADDR;
      ST_ST_ADDR: if (idx_r == pcnt_w && !pipe_r) state_nxt = ST_ST_META;
      ST_ST_META: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    now_nxt    = now_r;
    plen_nxt   = plen_r;
    pcnt_nxt   = pcnt_r;
    closed_nxt = closed_r;
    idx_nxt    = idx_r;
    pipe_nxt   = 1'b0;
    mism_nxt   = mism_r;
    clr_nxt    = clr_r;
    h_start    = 1'b0;
    h_restart  = closed_r;
    pk_we = 1'b0; pk_re = 1'b0;
    pa_we = 1'b0; pa_re = 1'b0;
    sk_we = 1'b0; sk_re = 1'b0;
    sa_we = 1'b0; sa_re = 1'b0;
    m_we  = 1'b0; m_re  = 1'b0;
    m_waddr = slot;
    m_wdata = '0;
    ov_nxt = ov_r && out_stall;
    oh_nxt = oh_r;
    oa_nxt = oa_r;
    oc_nxt = oc_r;
    ol_nxt = ol_r;
    unique case (state_r)
      ST_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
        clr_nxt = clr_r + HW'(1);
      end
      ST_IDLE: begin
        idx_nxt  = '0;
        mism_nxt = 1'b0;
        if (acc) begin
          case (in_command)
            CMD_KEY_BYTE: begin
              if (in_key_byte != '0) begin
                closed_nxt = 1'b0;
                h_start    = 1'b1;
                pk_we      = base_len < PLW'(KEY_BYTES - 1);
                plen_nxt   = (base_len < PLW'(KEY_BYTES)) ? base_len + PLW'(1) : base_len;
              end
            end
            CMD_LOOKUP: begin
              closed_nxt = 1'b1;
              m_re       = 1'b1;
            end
            CMD_ADD_ADDR: begin
              if (pcnt_r < CW'(MAX_ADDRESSES)) begin
                pa_we    = 1'b1;
                pcnt_nxt = pcnt_r + CW'(1);
              end
            end
            CMD_STORE: begin
              closed_nxt = 1'b1;
              if (overlong) begin
                m_we     = 1'b1;       // invalidate the slot
                pcnt_nxt = '0;
              end
            end
            CMD_TICK: now_nxt = now_r + STAMP_W'(1);
            default: ;
          endcase
        end
      end
      ST_HASH: ;
      ST_LK_META: ;
      ST_LK_CMP: begin
        if (idx_r != plen_w) begin
          pk_re    = 1'b1;
          sk_re    = 1'b1;
          idx_nxt  = idx_r + IW'(1);
          pipe_nxt = 1'b1;
        end
        if (pipe_r && pk_rdata != sk_rdata) mism_nxt = 1'b1;
      end
      ST_LK_AGE: begin
        idx_nxt = '0;
        if (expired) m_we = 1'b1;
      end
      ST_MISS, ST_EMPTY: begin
        if (free) begin
          ov_nxt = 1'b1;
          oh_nxt = (state_r == ST_EMPTY);
          oa_nxt = '0;
          oc_nxt = '0;
          ol_nxt = 1'b1;
        end
      end
      ST_ADDR_RD: sa_re = 1'b1;
      ST_ADDR_DATA: begin
        if (free) begin
          ov_nxt  = 1'b1;
          oh_nxt  = 1'b1;
          oa_nxt  = sa_rdata;
          oc_nxt  = m_rdata.addr_cnt;
          ol_nxt  = (idx_r + IW'(1) == mcnt_w);
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_ST_KEY: begin
        if (idx_r != plen_w) begin
          pk_re    = 1'b1;
          idx_nxt  = idx_r + IW'(1);
          pipe_nxt = 1'b1;
        end
        sk_we = pipe_r;
        if (idx_r == plen_w && !pipe_r) idx_nxt = '0;
      end
      ST_ST_ADDR: begin
        if (idx_r != pcnt_w) begin
          pa_re    = 1'b1;
          idx_nxt  = idx_r + IW'(1);
          pipe_nxt = 1'b1;
        end
        sa_we = pipe_r;
      end
      ST_ST_META: begin
        m_we             = 1'b1;
        m_wdata.valid    = 1'b1;
        m_wdata.key_len  = KLEN_W'(plen_r);
        m_wdata.addr_cnt = COUNT_W'(pcnt_r);
        m_wdata.stamp    = now_r;
        pcnt_nxt         = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      ttl_r    <= TTL_W'(TTL_RESET);
      now_r    <= '0;
      plen_r   <= '0;
      pcnt_r   <= '0;
      closed_r <= 1'b0;
      pipe_r   <= 1'b0;
      clr_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ttl_r    <= cfg_we ? cfg_wdata : ttl_r;
      now_r    <= now_nxt;
      plen_r   <= plen_nxt;
      pcnt_r   <= pcnt_nxt;
      closed_r <= closed_nxt;
      pipe_r   <= pipe_nxt;
      clr_r    <= clr_nxt;
      ov_r     <= ov_nxt;
    end
    idx_r  <= idx_nxt;
    mism_r <= mism_nxt;
    oh_r   <= oh_nxt;
    oa_r   <= oa_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = ov_r;
  assign out_hit           = oh_r;
  assign out_address       = oa_r;
  assign out_address_count = oc_r;
  assign out_last          = ol_r;

  // ---------------------------------------------------------------- checks
  a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_last && out_address_count == '0)
    else $error("miss result not a single empty item");

  a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= CW'(MAX_ADDRESSES))
    else $error("pending address count over limit");

  a_hash_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !h_busy)
    else $error("hash unit busy while accepting items");

endmodule

[bench/hashed_name_cache_with_expiry_tb.sv]
// Testbench for hashed_name_cache_with_expiry: directed and random transfers,
// with an in-bench cache predictor and a result checker. Depends on hnc_pkg.
module hashed_name_cache_with_expiry_tb;
  import hnc_pkg::*;

  localparam int SLOTS   = TABLE_ENTRIES_DEF;
  localparam int MAXADR  = MAX_ADDRESSES_DEF;
  localparam int KEYMAX  = KEY_BYTES_DEF;

  typedef struct {
    logic              hit;
    logic [ADDR_W-1:0] address;
    logic [COUNT_W-1:0] count;
    logic              last;
  } answer_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CMD_W-1:0] in_command;
  logic [BYTE_W-1:0] in_key_byte;
  logic [ADDR_W-1:0] in_address_value;
  logic out_valid;
  logic out_stall;
  logic out_hit;
  logic [ADDR_W-1:0] out_address;
  logic [COUNT_W-1:0] out_address_count;
  logic out_last;
  logic cfg_we;
  logic [TTL_W-1:0] cfg_wdata;

  hashed_name_cache_with_expiry dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_key_byte(in_key_byte), .in_address_value(in_address_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_address(out_address), .out_address_count(out_address_count),
    .out_last(out_last), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Predictor state: a mirror of the cache, the pending key and addresses.
  // ---------------------------------------------------------------------
  bit              cache_valid [SLOTS];
  logic [7:0]      cache_key   [SLOTS][KEYMAX-1];
  int unsigned     cache_klen  [SLOTS];
  logic [31:0]     cache_addr  [SLOTS][MAXADR];
  int unsigned     cache_acnt  [SLOTS];
  logic [31:0]     cache_stamp [SLOTS];
  logic [31:0]     seconds;
  logic [7:0]      key_buf     [KEYMAX-1];
  int unsigned     key_len;
  int unsigned     key_hash;
  logic [31:0]     addr_buf    [MAXADR];
  int unsigned     addr_cnt;
  bit              key_done;
  logic [TTL_W-1:0] ttl;

  answer_t answers_due[$];
  int      errors;
  bit      finishing;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard ceiling, far above a full run (clear pass, some 850 transfers,
  // 64-result lookups under long stalls).
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic void restart_key();
    key_len  = 0;
    key_hash = HASH_SEED % SLOTS;
    key_done = 0;
  endfunction

  // Applies one accepted transfer to the mirror and queues its answers.
  function automatic void predict_cache(input logic [CMD_W-1:0] cmd,
                                        input logic [7:0] kb,
                                        input logic [31:0] av);
    int unsigned slot;
    int unsigned n;
    bit same;
    answer_t a;
    slot = key_hash % SLOTS;
    case (cmd)
      CMD_KEY_BYTE: begin
        if (kb != 0) begin
          if (key_done) restart_key();
          if (key_len < KEYMAX - 1) key_buf[key_len] = kb;
          if (key_len < KEYMAX) key_len++;
          key_hash = (key_hash * HASH_MULT + kb) % SLOTS;
        end
      end
      CMD_LOOKUP: begin
        key_done = 1;
        same = (key_len <= KEYMAX - 1) && cache_valid[slot] &&
               (cache_klen[slot] == key_len);
        if (same)
          for (int i = 0; i < key_len; i++)
            if (cache_key[slot][i] != key_buf[i]) same = 0;
        a.address = '0;
        a.count   = '0;
        a.last    = 1'b1;
        if (!same) begin
          a.hit = 1'b0;
          answers_due.push_back(a);
        end else if (seconds - cache_stamp[slot] > {16'd0, ttl}) begin
          cache_valid[slot] = 0;   // expired entry is dropped by the lookup
          a.hit = 1'b0;
          answers_due.push_back(a);
        end else begin
          n = cache_acnt[slot];
          a.hit = 1'b1;
          if (n == 0) answers_due.push_back(a);
          for (int i = 0; i < n; i++) begin
            a.address = cache_addr[slot][i];
            a.count   = n[COUNT_W-1:0];
            a.last    = (i + 1 == n);
            answers_due.push_back(a);
          end
        end
      end
      CMD_ADD_ADDR: begin
        if (addr_cnt < MAXADR) begin
          addr_buf[addr_cnt] = av;
          addr_cnt++;
        end
      end
      CMD_STORE: begin
        key_done = 1;
        if (key_len > KEYMAX - 1) cache_valid[slot] = 0;
        else begin
          for (int i = 0; i < key_len; i++) cache_key[slot][i] = key_buf[i];
          for (int i = 0; i < addr_cnt; i++) cache_addr[slot][i] = addr_buf[i];
          cache_klen[slot]  = key_len;
          cache_acnt[slot]  = addr_cnt;
          cache_stamp[slot] = seconds;
          cache_valid[slot] = 1;
        end
        addr_cnt = 0;
      end
      CMD_TICK: seconds = seconds + 1;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Send one transfer with a random gap before it; predict on acceptance.
  // ---------------------------------------------------------------------
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [7:0] kb,
                           input logic [31:0] av);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
        : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_key_byte      <= kb;
    in_address_value <= av;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_cache(cmd, kb, av);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result stall: mostly off, some short stalls, a few long ones.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n) out_stall <= 1'b0;
    else if (r < 65) out_stall <= 1'b0;
    else if (r < 97) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 3) != 0);
  end

  // Checker: compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0)
        report_mismatch("result transfer with nothing expected");
      else begin
        a = answers_due.pop_front();
        if (out_hit !== a.hit)
          report_mismatch($sformatf("hit %0b, want %0b", out_hit, a.hit));
        if (out_address !== a.address)
          report_mismatch($sformatf("address %h, want %h", out_address, a.address));
        if (out_address_count !== a.count)
          report_mismatch($sformatf("count %0d, want %0d", out_address_count, a.count));
        if (out_last !== a.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, a.last));
      end
    end
  end

  // Go idle, wait for all answers, then for the worst store/key-byte latency.
  task automatic drain();
    go_idle();
    while (answers_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [TTL_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ttl = v;
  endtask

  task automatic send_name(input string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_KEY_BYTE, s[i], '0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    // Miss on an empty table, then store two addresses and hit.
    send_name("ab");
    send_item(CMD_LOOKUP, 0, 0);
    send_item(CMD_ADD_ADDR, 0, 32'hFFFF_FFFF);
    send_item(CMD_ADD_ADDR, 0, 32'h0000_0000);
    send_item(CMD_STORE, 0, 0);
    send_item(CMD_LOOKUP, 0, 0);
    // Zero key byte is ignored; byte 255 starts a new key.
    send_item(CMD_KEY_BYTE, 8'h00, 0);
    send_item(CMD_KEY_BYTE, 8'hFF, 0);
    send_item(CMD_LOOKUP, 0, 0);
    // Empty hit: store with no addresses.
    send_item(CMD_STORE, 0, 0);
    send_item(CMD_LOOKUP, 0, 0);
    // Unused commands.
    send_item(3'd5, 8'h55, 32'h1);
    send_item(3'd6, 8'hAA, 32'h2);
    send_item(3'd7, 8'h01, 32'h3);
    send_item(CMD_TICK, 0, 0);
    send_item(CMD_LOOKUP, 0, 0);
  endtask

  task automatic test_expiry();
    write_ttl(16'd0);
    send_name("x");
    send_item(CMD_STORE, 0, 0);
    send_item(CMD_LOOKUP, 0, 0);   // age 0: hit
    send_item(CMD_TICK, 0, 0);
    send_item(CMD_LOOKUP, 0, 0);   // age 1 > 0: expired, cleared
    send_item(CMD_TICK, 0, 0);
    send_item(CMD_LOOKUP, 0, 0);   // now invalid
    write_ttl(16'd2);
    send_name("y");
    send_item(CMD_STORE, 0, 0);
    repeat (2) send_item(CMD_TICK, 0, 0);
    send_item(CMD_LOOKUP, 0, 0);   // age equals ttl: still a hit
    send_item(CMD_TICK, 0, 0);
    send_item(CMD_LOOKUP, 0, 0);
  endtask

  task automatic test_limits();
    write_ttl(16'hFFFF);
    // Full address list plus extras that are dropped.
    send_name("full");
    for (int i = 0; i < MAXADR + 3; i++) send_item(CMD_ADD_ADDR, 0, $urandom);
    send_item(CMD_STORE, 0, 0);
    send_item(CMD_LOOKUP, 0, 0);
    // Longest accepted key, then overlong key: lookup misses, store clears.
    for (int i = 0; i < KEYMAX - 1; i++)
      send_item(CMD_KEY_BYTE, BYTE_W'($urandom_range(1, 255)), 0);
    send_item(CMD_ADD_ADDR, 0, $urandom);
    send_item(CMD_STORE, 0, 0);
    send_item(CMD_LOOKUP, 0, 0);
    for (int i = 0; i < KEYMAX + 2; i++) send_item(CMD_KEY_BYTE, 8'h41, 0);
    send_item(CMD_LOOKUP, 0, 0);
    send_item(CMD_STORE, 0, 0);
    send_item(CMD_LOOKUP, 0, 0);
  endtask

  // Random: mostly well-formed store/lookup sequences over a small name
  // pool so that hits, collisions and expiry all occur.
  task automatic test_random(input int items);
    int sent;
    int kind;
    int len;
    byte unsigned pool [8][6];
    int pool_len [8];
    int p;
    sent = 0;
    for (int i = 0; i < 8; i++) begin
      pool_len[i] = $urandom_range(1, 6);
      for (int j = 0; j < 6; j++) pool[i][j] = 8'($urandom_range(1, 255));
    end
    while (sent < items) begin
      kind = $urandom_range(0, 9);
      p = $urandom_range(0, 7);
      if (kind < 7) begin
        for (int j = 0; j < pool_len[p]; j++) send_item(CMD_KEY_BYTE, pool[p][j], 0);
        sent += pool_len[p];
        if (kind < 3) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 66) : $urandom_range(0, 4);
          for (int j = 0; j < len; j++) send_item(CMD_ADD_ADDR, 0, $urandom);
          send_item(CMD_STORE, 0, 0);
          sent += len + 1;
        end else begin
          send_item(CMD_LOOKUP, 0, 0);
          sent++;
        end
      end else if (kind == 7) begin
        send_item(CMD_TICK, 0, 0);
        sent++;
      end else begin
        // noise: any command, any field value
        send_item(CMD_W'($urandom_range(0, 7)), BYTE_W'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = '0;
    in_key_byte      = '0;
    in_address_value = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    errors           = 0;
    for (int i = 0; i < SLOTS; i++) cache_valid[i] = 0;
    seconds  = '0;
    addr_cnt = 0;
    ttl      = TTL_RESET;
    restart_key();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_expiry();
    test_limits();
    write_ttl(16'd3);
    test_random(120);
    write_ttl(16'd60);
    test_random(110);
    drain();

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
